/* src/afc_pkg.sv */
`default_nettype none

package afc_pkg;

  localparam int COORD_W    = 24;
  localparam int COEF_W     = 16;
  localparam int COMP_W     = COEF_W + 1;
  localparam int PROD_W     = COMP_W + COORD_W;
  localparam int SUM_W      = PROD_W + 3;
  localparam int W_SHIFT    = 8;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_PLANES = 6;
  localparam int CELL_DEPTH = 2;
  localparam int IN_DATA_W  = 6 * COORD_W;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NUM_ROWS * COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    MATRIX_COL0 = 2'd0,
    MATRIX_COL1 = 2'd1,
    MATRIX_COL2 = 2'd2,
    MATRIX_COL3 = 2'd3
  } cfg_idx_t;

  // min_x sits in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
  } box_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] w;
  } plane_t;

  typedef logic [3:0][CFG_DATA_W-1:0] matrix_t;

  function automatic logic signed [COMP_W-1:0] plane_comp(
    input matrix_t m, input int col, input int row, input logic neg);
    logic signed [COEF_W-1:0] base;
    logic signed [COEF_W-1:0] other;
    base  = signed'(m[col][COEF_W*(NUM_ROWS-1) +: COEF_W]);
    other = signed'(m[col][COEF_W*row +: COEF_W]);
    if (neg) begin
      return COMP_W'(base) - COMP_W'(other);
    end
    return COMP_W'(base) + COMP_W'(other);
  endfunction

  function automatic plane_t make_plane(input matrix_t m, input int row, input logic neg);
    plane_t p;
    p.x = plane_comp(m, 0, row, neg);
    p.y = plane_comp(m, 1, row, neg);
    p.z = plane_comp(m, 2, row, neg);
    p.w = plane_comp(m, 3, row, neg);
    return p;
  endfunction

endpackage

`default_nettype wire

/* src/aabb_frustum_cull.sv */
// Box visibility test against the six frustum planes of a view-projection matrix.
// Input stream s_*: one beat per box, tdata carries the min and max corners as
// signed Q15.8 values. Output stream m_*: one beat per box, tdata bit 0 is the
// visible flag, 1 when no plane rejects the box.
// Config channel cfg_*: writes matrix column cfg_index (0..3) with cfg_data,
// four signed Q3.12 rows, row 0 lowest. Always ready; write only while idle.
// The box travels through a row of six plane cells, one per frustum plane.
// Each cell: stage a registers three parallel 17x24 multiplies, stage b the
// sum with the plane w and a sign test; the visible flag is and-ed along.
// Throughput: one box per cycle while m_tready stays high. Each stage holds
// its beat only while the stage after it is full and stalled, so empty stages
// keep filling while m_tready is low; s_tready drops once all 12 stages are
// occupied.
// Reset clears the pipeline and the matrix; with a zero matrix every box is visible.
`default_nettype none

module aabb_frustum_cull (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z
  input  wire logic [afc_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // visible, zero pad
  output logic [afc_pkg::OUT_DATA_W-1:0]          m_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [afc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [afc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  afc_pkg::matrix_t  matrix;
  afc_pkg::plane_t   planes [afc_pkg::NUM_PLANES];

  logic              chain_valid [afc_pkg::NUM_PLANES+1];
  logic              chain_ready [afc_pkg::NUM_PLANES+1];
  afc_pkg::box_t     chain_box   [afc_pkg::NUM_PLANES+1];
  logic              chain_vis   [afc_pkg::NUM_PLANES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= '0;
    end else if (cfg_valid) begin
      unique case (afc_pkg::cfg_idx_t'(cfg_index))
        afc_pkg::MATRIX_COL0: matrix[0] <= cfg_data;
        afc_pkg::MATRIX_COL1: matrix[1] <= cfg_data;
        afc_pkg::MATRIX_COL2: matrix[2] <= cfg_data;
        afc_pkg::MATRIX_COL3: matrix[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign chain_valid[0] = s_tvalid;
  assign s_tready       = chain_ready[0];
  assign chain_box[0]   = afc_pkg::box_t'(s_tdata);
  assign chain_vis[0]   = 1'b1;

  // plane p: row 3 plus row p/2 for even p, minus for odd p
  for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_cell
    assign planes[p] = afc_pkg::make_plane(matrix, p / 2, 1'((p % 2) != 0));

    afc_plane_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .plane     (planes[p]),
      .in_valid  (chain_valid[p]),
      .in_ready  (chain_ready[p]),
      .in_box    (chain_box[p]),
      .in_vis    (chain_vis[p]),
      .out_valid (chain_valid[p+1]),
      .out_ready (chain_ready[p+1]),
      .out_box   (chain_box[p+1]),
      .out_vis   (chain_vis[p+1])
    );
  end

  assign chain_ready[afc_pkg::NUM_PLANES] = m_tready;
  assign m_tvalid = chain_valid[afc_pkg::NUM_PLANES];
  assign m_tdata  = afc_pkg::OUT_DATA_W'(chain_vis[afc_pkg::NUM_PLANES]);

  logic unused_box;
  assign unused_box = ^chain_box[afc_pkg::NUM_PLANES];

endmodule

`default_nettype wire

/* src/afc_plane_cell.sv */
`default_nettype none

module afc_plane_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire afc_pkg::plane_t plane,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire afc_pkg::box_t in_box,
  input  wire logic          in_vis,
  output logic               out_valid,
  input  wire logic          out_ready,
  output afc_pkg::box_t      out_box,
  output logic               out_vis
);

  logic                                  a_valid;
  logic                                  a_ready;
  afc_pkg::box_t                         a_box;
  logic                                  a_vis;
  logic signed [afc_pkg::PROD_W-1:0]     a_prod_x;
  logic signed [afc_pkg::PROD_W-1:0]     a_prod_y;
  logic signed [afc_pkg::PROD_W-1:0]     a_prod_z;
  logic signed [afc_pkg::COMP_W-1:0]     a_w;

  logic                                  b_valid;
  logic                                  b_ready;
  afc_pkg::box_t                         b_box;
  logic                                  b_vis;

  logic signed [afc_pkg::COORD_W-1:0]    sel_x;
  logic signed [afc_pkg::COORD_W-1:0]    sel_y;
  logic signed [afc_pkg::COORD_W-1:0]    sel_z;
  logic signed [afc_pkg::PROD_W-1:0]     a_prod_x_next;
  logic signed [afc_pkg::PROD_W-1:0]     a_prod_y_next;
  logic signed [afc_pkg::PROD_W-1:0]     a_prod_z_next;
  logic signed [afc_pkg::SUM_W-1:0]      sum;
  logic                                  b_vis_next;

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // p-vertex: max corner where the normal component is non-negative
  always_comb begin
    sel_x = plane.x[afc_pkg::COMP_W-1] ? in_box.min_x : in_box.max_x;
    sel_y = plane.y[afc_pkg::COMP_W-1] ? in_box.min_y : in_box.max_y;
    sel_z = plane.z[afc_pkg::COMP_W-1] ? in_box.min_z : in_box.max_z;
    a_prod_x_next = afc_pkg::PROD_W'(plane.x) * afc_pkg::PROD_W'(sel_x);
    a_prod_y_next = afc_pkg::PROD_W'(plane.y) * afc_pkg::PROD_W'(sel_y);
    a_prod_z_next = afc_pkg::PROD_W'(plane.z) * afc_pkg::PROD_W'(sel_z);
  end

  always_comb begin
    sum = afc_pkg::SUM_W'(a_prod_x) + afc_pkg::SUM_W'(a_prod_y)
        + afc_pkg::SUM_W'(a_prod_z) + (afc_pkg::SUM_W'(a_w) <<< afc_pkg::W_SHIFT);
    b_vis_next = a_vis && !sum[afc_pkg::SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_box    <= in_box;
      a_vis    <= in_vis;
      a_prod_x <= a_prod_x_next;
      a_prod_y <= a_prod_y_next;
      a_prod_z <= a_prod_z_next;
      a_w      <= plane.w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_box <= a_box;
      b_vis <= b_vis_next;
    end
  end

  assign out_valid = b_valid;
  assign out_box   = b_box;
  assign out_vis   = b_vis;

endmodule

`default_nettype wire

/* src/afc_checker.sv */
`default_nettype none

module afc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic [afc_pkg::IN_DATA_W-1:0]      s_tdata,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [afc_pkg::OUT_DATA_W-1:0]     m_tdata,
  input wire logic                               cfg_valid,
  input wire logic                               cfg_ready,
  input wire logic [afc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input wire logic [afc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = afc_pkg::NUM_PLANES * afc_pkg::CELL_DEPTH;

  logic       in_beat;
  logic       out_beat;
  logic [4:0] pending;
  logic       unused_ports;

  assign in_beat      = s_tvalid && s_tready;
  assign out_beat     = m_tvalid && m_tready;
  assign unused_ports = ^{s_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 5'(in_beat) - 5'(out_beat);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[afc_pkg::OUT_DATA_W-1:1] == '0)
    else $error("pad bits of output beat not zero");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 5'd0)
    else $error("output beat without an outstanding box");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 5'(DEPTH))
    else $error("more boxes in flight than pipeline stages");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (.*);

`default_nettype wire
